FILE: hw/rtl/tcfpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfpd_pkg
// shared types, constants and the arctangent table of the tilt filter
// ----------------------------------------------------------------------------
package tcfpd_pkg;

	localparam int CORDIC_STEPS     = 16;
	localparam int SAMPLE_PERIOD_MS = 10;
	localparam int SQRT_STEPS       = 16;
	localparam int STEP_W           = 5;

	typedef enum logic [2:0] {
		REG_GYRO_OFFSET  = 3'd0,
		REG_BLEND_WEIGHT = 3'd1,
		REG_GAIN_P       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_ANGLE_TARGET = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQRT,
		OP_CINIT,
		OP_CORD,
		OP_TILT,
		OP_MUL1,
		OP_MUL2,
		OP_DIV,
		OP_REC,
		OP_ANG,
		OP_PD1,
		OP_PD2,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] gyro_offset;
		logic        [15:0] blend_weight;
		logic        [15:0] gain_p;
		logic signed [15:0] gain_d;
		logic signed [15:0] angle_target;
	} cfg_t;

	// arctangent of 2^-i in 1/65536 degree
	function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/tcfpd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfpd_regs
// configuration registers with their reset values
// ----------------------------------------------------------------------------
module tcfpd_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [15:0]          cfg_wdata,
	output tcfpd_pkg::cfg_t      cfg
);

	tcfpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_offset  <= 16'sd240;
			cfg_q.blend_weight <= 16'd64225;
			cfg_q.gain_p       <= 16'd12800;
			cfg_q.gain_d       <= 16'sd0;
			cfg_q.angle_target <= 16'sd2048;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tcfpd_pkg::REG_GYRO_OFFSET:  cfg_q.gyro_offset  <= cfg_wdata;
				tcfpd_pkg::REG_BLEND_WEIGHT: cfg_q.blend_weight <= cfg_wdata;
				tcfpd_pkg::REG_GAIN_P:       cfg_q.gain_p       <= cfg_wdata;
				tcfpd_pkg::REG_GAIN_D:       cfg_q.gain_d       <= cfg_wdata;
				tcfpd_pkg::REG_ANGLE_TARGET: cfg_q.angle_target <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/tcfpd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfpd_dp
// datapath: gyro scaling, square root, cordic, blend and pd law
// ----------------------------------------------------------------------------
module tcfpd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcfpd_pkg::cmd_t      cmd,
	input  tcfpd_pkg::cfg_t      cfg,
	input  logic [63:0]          in_data,
	output logic signed [23:0]   tilt_angle,
	output logic signed [17:0]   tilt_rate,
	output logic signed [15:0]   drive_power
);

	logic signed [15:0] ax_q;
	logic signed [17:0] rate_q;
	logic        [31:0] rem_q;
	logic        [31:0] res_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [24:0] z_q;
	logic               zero_q;
	logic signed [15:0] acc_q;
	logic signed [25:0] acc1k_q;
	logic signed [35:0] pred_q;
	logic signed [52:0] p1_q;
	logic signed [52:0] p2_q;
	logic        [30:0] w_q;
	logic signed [23:0] ang_q;
	logic signed [23:0] fused_q;
	logic signed [24:0] err_q;
	logic signed [41:0] pp_q;
	logic signed [42:0] sum_q;
	logic signed [23:0] out_ang_q;
	logic signed [17:0] out_rate_q;
	logic signed [15:0] out_pw_q;

	logic signed [15:0] in_ax, in_ay, in_az, in_g, g_sum;
	logic signed [34:0] g_prod;
	logic signed [31:0] ay2, az2;
	logic        [31:0] bitv;
	logic        [32:0] trial;
	logic signed [33:0] xs, ys;
	logic signed [24:0] zr;
	logic signed [24:0] atan_s;
	logic signed [16:0] t_raw;
	logic signed [15:0] t_clamp;
	logic        [16:0] wr;
	logic signed [52:0] num;
	logic signed [36:0] v_raw, v_clamp, u_full;
	logic        [62:0] rec_prod;
	logic        [23:0] q;
	logic signed [42:0] s_adj;
	logic signed [26:0] pw_raw;
	logic signed [15:0] pw_clamp;

	always_comb begin
		in_ax  = in_data[15:0];
		in_ay  = in_data[31:16];
		in_az  = in_data[47:32];
		in_g   = in_data[63:48];
		g_sum  = in_g + cfg.gyro_offset;
		g_prod = 35'(g_sum) * 35'sd255999;
		ay2    = 32'(in_ay) * 32'(in_ay);
		az2    = 32'(in_az) * 32'(in_az);

		bitv   = 32'h4000_0000 >> {cmd.step, 1'b0};
		trial  = {1'b0, res_q} + {1'b0, bitv};

		xs     = x_q >>> cmd.step;
		ys     = y_q >>> cmd.step;
		atan_s = 25'($signed({1'b0, tcfpd_pkg::atan_lut(cmd.step)}));

		zr     = z_q + 25'sd128;
		t_raw  = zr[24:8];
		if (t_raw > 17'sd23040)
			t_clamp = 16'sd23040;
		else if (t_raw < -17'sd23040)
			t_clamp = -16'sd23040;
		else
			t_clamp = t_raw[15:0];

		wr     = 17'(17'd65536 - {1'b0, cfg.blend_weight});
		num    = p1_q + p2_q;
		v_raw  = num[52:16];
		if (v_raw > 37'sd8388607999)
			v_clamp = 37'sd8388607999;
		else if (v_raw < -37'sd8388608000)
			v_clamp = -37'sd8388608000;
		else
			v_clamp = v_raw;
		u_full = v_clamp + 37'sd8388608000;

		rec_prod = 63'(w_q) * 63'd2199023256;
		q        = rec_prod[61:38];

		s_adj  = sum_q + (sum_q[42] ? 43'sd65535 : 43'sd0);
		pw_raw = s_adj[42:16];
		if (pw_raw > 27'sd32767)
			pw_clamp = 16'sd32767;
		else if (pw_raw < -27'sd32767)
			pw_clamp = -16'sd32767;
		else
			pw_clamp = pw_raw[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fused_q <= '0;
		end else if (cmd.op == tcfpd_pkg::OP_ANG) begin
			fused_q <= ang_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			tcfpd_pkg::OP_LOAD: begin
				ax_q   <= in_ax;
				rate_q <= g_prod[33:16];
				rem_q  <= unsigned'(ay2) + unsigned'(az2);
				res_q  <= '0;
			end
			tcfpd_pkg::OP_SQRT: begin
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= 32'(33'(rem_q) - trial);
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			tcfpd_pkg::OP_CINIT: begin
				x_q    <= $signed({4'd0, res_q[15:0], 14'd0});
				y_q    <= $signed({{4{ax_q[15]}}, ax_q, 14'd0});
				z_q    <= '0;
				zero_q <= (res_q == 32'd0) && (ax_q == 16'sd0);
			end
			tcfpd_pkg::OP_CORD: begin
				if (!y_q[33]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_s;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_s;
				end
			end
			tcfpd_pkg::OP_TILT: begin
				acc_q  <= zero_q ? 16'sd0 : t_clamp;
				pred_q <= 36'(fused_q) * 36'sd1000
					+ 36'(rate_q) * 36'(tcfpd_pkg::SAMPLE_PERIOD_MS);
			end
			tcfpd_pkg::OP_MUL1: begin
				p1_q    <= 53'($signed({1'b0, cfg.blend_weight})) * 53'(pred_q);
				acc1k_q <= 26'(acc_q) * 26'sd1000;
			end
			tcfpd_pkg::OP_MUL2: begin
				p2_q <= 53'($signed({1'b0, wr})) * 53'(acc1k_q);
			end
			tcfpd_pkg::OP_DIV: begin
				w_q <= u_full[33:3];
			end
			tcfpd_pkg::OP_REC: begin
				ang_q <= $signed({~q[23], q[22:0]});
			end
			tcfpd_pkg::OP_ANG: begin
				err_q <= 25'(ang_q) - 25'(cfg.angle_target);
			end
			tcfpd_pkg::OP_PD1: begin
				pp_q <= 42'($signed({1'b0, cfg.gain_p})) * 42'(err_q);
			end
			tcfpd_pkg::OP_PD2: begin
				sum_q <= 43'(pp_q) + 43'(cfg.gain_d) * 43'(rate_q);
			end
			tcfpd_pkg::OP_OUT: begin
				out_ang_q  <= fused_q;
				out_rate_q <= rate_q;
				out_pw_q   <= pw_clamp;
			end
			default: ;
		endcase
	end

	assign tilt_angle  = out_ang_q;
	assign tilt_rate   = out_rate_q;
	assign drive_power = out_pw_q;

endmodule

FILE: hw/rtl/tcfpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfpd_ctrl
// sequencer for one sample and the output beat handshake
// ----------------------------------------------------------------------------
module tcfpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output tcfpd_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQRT, ST_CINIT, ST_CORD, ST_TILT, ST_MUL1, ST_MUL2,
		ST_DIV, ST_REC, ST_ANG, ST_PD1, ST_PD2, ST_OUT
	} state_t;

	localparam logic [tcfpd_pkg::STEP_W-1:0] SQRT_LAST =
		tcfpd_pkg::STEP_W'(tcfpd_pkg::SQRT_STEPS - 1);
	localparam logic [tcfpd_pkg::STEP_W-1:0] CORD_LAST =
		tcfpd_pkg::STEP_W'(tcfpd_pkg::CORDIC_STEPS - 1);

	state_t                      state_q;
	logic [tcfpd_pkg::STEP_W-1:0] cnt_q;
	logic                        mvalid_q;
	logic                        out_free;

	assign out_free = !mvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

	always_comb begin
		cmd.step = cnt_q;
		unique case (state_q)
			ST_IDLE:  cmd.op = s_tvalid ? tcfpd_pkg::OP_LOAD : tcfpd_pkg::OP_NONE;
			ST_SQRT:  cmd.op = tcfpd_pkg::OP_SQRT;
			ST_CINIT: cmd.op = tcfpd_pkg::OP_CINIT;
			ST_CORD:  cmd.op = tcfpd_pkg::OP_CORD;
			ST_TILT:  cmd.op = tcfpd_pkg::OP_TILT;
			ST_MUL1:  cmd.op = tcfpd_pkg::OP_MUL1;
			ST_MUL2:  cmd.op = tcfpd_pkg::OP_MUL2;
			ST_DIV:   cmd.op = tcfpd_pkg::OP_DIV;
			ST_REC:   cmd.op = tcfpd_pkg::OP_REC;
			ST_ANG:   cmd.op = tcfpd_pkg::OP_ANG;
			ST_PD1:   cmd.op = tcfpd_pkg::OP_PD1;
			ST_PD2:   cmd.op = tcfpd_pkg::OP_PD2;
			ST_OUT:   cmd.op = out_free ? tcfpd_pkg::OP_OUT : tcfpd_pkg::OP_NONE;
			default:  cmd.op = tcfpd_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			mvalid_q <= (state_q == ST_OUT && out_free) || (mvalid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_CINIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CINIT: state_q <= ST_CORD;
				ST_CORD: begin
					if (cnt_q == CORD_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_TILT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TILT: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_REC;
				ST_REC:  state_q <= ST_ANG;
				ST_ANG:  state_q <= ST_PD1;
				ST_PD1:  state_q <= ST_PD2;
				ST_PD2:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SQRT && cnt_q == '0))
		else $error("accepted beat did not start the square root");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (cnt_q <= SQRT_LAST))
		else $error("square root step out of range");
	a_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && mvalid_q && !m_tready) |=> (state_q == ST_OUT))
		else $error("result overwrote a beat still waiting");
`endif

endmodule

FILE: hw/rtl/tilt_complementary_filter_pd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter_pd
// complementary tilt filter with pd drive output
// ----------------------------------------------------------------------------
// One sample beat in gives one result beat out. From acceptance until its
// result is offered, a sample passes through the bit-serial square root, the
// cordic setup and the shared cordic rotator, sequenced multiplies for
// blending and the pd law, and the output load. The next sample can be
// accepted at the earliest in the same cycle in which the result is first
// offered. A new sample is taken once the previous one has left the
// sequencer, even while its result still waits.
// Configuration writes are taken at any cycle and should be made while idle.
module tilt_complementary_filter_pd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_raw
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // tilt_angle, tilt_rate, drive_power, zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	tcfpd_pkg::cmd_t    cmd;
	tcfpd_pkg::cfg_t    cfg;
	logic signed [23:0] tilt_angle;
	logic signed [17:0] tilt_rate;
	logic signed [15:0] drive_power;

	tcfpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tcfpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tcfpd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.in_data     (s_tdata),
		.tilt_angle  (tilt_angle),
		.tilt_rate   (tilt_rate),
		.drive_power (drive_power)
	);

	assign m_tdata = {6'd0, drive_power, tilt_rate, tilt_angle};

endmodule
